>>> rtl/core/sorted_priority_queue_core_defines.svh
// Assertion macros for the sorted priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Clocked property, ignored while reset is asserted.
`define SPQ_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication in the same clocked, reset-gated form.
`define SPQ_IMPLY(lbl, ante, cons, msg) \
	`SPQ_CHECK(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY_DEF     = 16;
	localparam int PRIO_BITS_DEF    = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int OPCODE_W  = 2;
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 32;
	localparam int COUNT_W   = 5;
	localparam int STATUS_W  = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell #(
	parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  spq_pkg::cell_ctl_t      ctl,
	input  logic                    occupied,
	input  logic                    left_keep,
	input  logic [PRIO_BITS-1:0]    new_prio,
	input  logic [PAYLOAD_BITS-1:0] new_pay,
	input  logic [PRIO_BITS-1:0]    left_prio,
	input  logic [PAYLOAD_BITS-1:0] left_pay,
	input  logic [PRIO_BITS-1:0]    right_prio,
	input  logic [PAYLOAD_BITS-1:0] right_pay,
	output logic [PRIO_BITS-1:0]    prio,
	output logic [PAYLOAD_BITS-1:0] pay,
	output logic                    keep
);

	logic [PRIO_BITS-1:0]    prio_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	assign keep = occupied && (prio_q >= new_prio);
	assign prio = prio_q;
	assign pay  = pay_q;

	always_ff @(posedge clk) begin
		if (ctl.rem) begin
			prio_q <= right_prio;
			pay_q  <= right_pay;
		end else if (ctl.ins && !keep) begin
			if (left_keep) begin
				prio_q <= new_prio;
				pay_q  <= new_pay;
			end else begin
				prio_q <= left_prio;
				pay_q  <= left_pay;
			end
		end
	end

endmodule

>>> rtl/core/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Sorted priority queue built as a row of CAPACITY compare cells, highest
// priority in cell 0, equal priorities kept in arrival order. Every cell
// compares its own entry with the incoming key in parallel and then holds,
// loads the new word or takes its neighbour's entry, so each operation
// completes as it is accepted: a command word is taken every cycle while
// the response side keeps up, and its response word appears in the output
// register in the cycle after acceptance. Throughput is set by that single
// output register: cmd_ready drops only while a response waits unread.
module sorted_priority_queue_core #(
	parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
	parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [spq_pkg::OPCODE_W-1:0]  opcode,
	input  logic [spq_pkg::KEY_W-1:0]     key_priority,
	input  logic [spq_pkg::PAY_W-1:0]     payload,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [spq_pkg::PAY_W-1:0]     head_payload,
	output logic [spq_pkg::KEY_W-1:0]     head_priority,
	output logic                          is_empty,
	output logic [spq_pkg::COUNT_W-1:0]   entry_count,
	output logic [spq_pkg::STATUS_W-1:0]  status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic                    fire;
	logic                    full;
	logic                    empty;
	logic [63:0]             key_ext;
	logic [63:0]             pay_ext;
	logic [PRIO_BITS-1:0]    key_w;
	logic [PAYLOAD_BITS-1:0] pay_w;
	spq_pkg::cell_ctl_t      ctl;
	spq_pkg::status_t        st_nxt;
	logic [PRIO_BITS-1:0]    head_prio_nxt;
	logic [PAYLOAD_BITS-1:0] head_pay_nxt;

	logic [PRIO_BITS-1:0]    cell_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0] cell_pay  [CAPACITY];
	logic                    cell_keep [CAPACITY];

	logic                    res_valid_q;
	logic [spq_pkg::PAY_W-1:0]    res_pay_q;
	logic [spq_pkg::KEY_W-1:0]    res_prio_q;
	logic                         res_empty_q;
	logic [spq_pkg::COUNT_W-1:0]  res_count_q;
	spq_pkg::status_t             res_status_q;

	assign cmd_ready = !res_valid_q || res_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign key_ext   = 64'(key_priority);
	assign pay_ext   = 64'(payload);
	assign key_w     = key_ext[PRIO_BITS-1:0];
	assign pay_w     = pay_ext[PAYLOAD_BITS-1:0];

	always_comb begin
		ctl           = '0;
		count_nxt     = count_q;
		st_nxt        = spq_pkg::ST_OK;
		head_prio_nxt = cell_prio[0];
		head_pay_nxt  = cell_pay[0];
		case (opcode)
			spq_pkg::OP_INSERT: begin
				if (full) begin
					st_nxt = spq_pkg::ST_FULL;
				end else begin
					ctl.ins   = fire;
					count_nxt = count_q + CNT_W'(1);
					if (empty || (key_w > cell_prio[0])) begin
						head_prio_nxt = key_w;
						head_pay_nxt  = pay_w;
					end
				end
			end
			spq_pkg::OP_REMOVE: begin
				if (empty) begin
					st_nxt = spq_pkg::ST_EMPTY;
				end else begin
					ctl.rem   = fire;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					st_nxt = spq_pkg::ST_EMPTY;
				end
			end
		endcase
		if (st_nxt == spq_pkg::ST_EMPTY) begin
			head_prio_nxt = '0;
			head_pay_nxt  = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    occ;
		logic                    lkeep;
		logic [PRIO_BITS-1:0]    lprio;
		logic [PAYLOAD_BITS-1:0] lpay;
		logic [PRIO_BITS-1:0]    rprio;
		logic [PAYLOAD_BITS-1:0] rpay;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lkeep = 1'b1;
			assign lprio = key_w;
			assign lpay  = pay_w;
		end else begin : g_inner
			assign lkeep = cell_keep[i-1];
			assign lprio = cell_prio[i-1];
			assign lpay  = cell_pay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rprio = cell_prio[i];
			assign rpay  = cell_pay[i];
		end else begin : g_body
			assign rprio = cell_prio[i+1];
			assign rpay  = cell_pay[i+1];
		end

		spq_cell #(
			.PRIO_BITS    (PRIO_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.left_keep  (lkeep),
			.new_prio   (key_w),
			.new_pay    (pay_w),
			.left_prio  (lprio),
			.left_pay   (lpay),
			.right_prio (rprio),
			.right_pay  (rpay),
			.prio       (cell_prio[i]),
			.pay        (cell_pay[i]),
			.keep       (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	logic [63:0] hp_ext;
	logic [63:0] hy_ext;
	logic [63:0] cnt_ext;

	assign hp_ext  = 64'(head_prio_nxt);
	assign hy_ext  = 64'(head_pay_nxt);
	assign cnt_ext = 64'(count_nxt);

	always_ff @(posedge clk) begin
		if (fire) begin
			res_pay_q    <= hy_ext[spq_pkg::PAY_W-1:0];
			res_prio_q   <= hp_ext[spq_pkg::KEY_W-1:0];
			res_empty_q  <= (count_nxt == '0);
			res_count_q  <= cnt_ext[spq_pkg::COUNT_W-1:0];
			res_status_q <= st_nxt;
		end
	end

	assign res_valid     = res_valid_q;
	assign head_payload  = res_pay_q;
	assign head_priority = res_prio_q;
	assign is_empty      = res_empty_q;
	assign entry_count   = res_count_q;
	assign status        = res_status_q;

endmodule

>>> rtl/core/spq_checker.sv
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module spq_checker #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [spq_pkg::PAY_W-1:0]     head_payload,
	input logic [spq_pkg::KEY_W-1:0]     head_priority,
	input logic                          is_empty,
	input logic [spq_pkg::COUNT_W-1:0]   entry_count,
	input logic [spq_pkg::STATUS_W-1:0]  status
);

	localparam int CAP_W = (CAPACITY > 64) ? 64 : 64;

	logic [CAP_W-1:0] cap_ext;

	assign cap_ext = CAP_W'(CAPACITY);

	`SPQ_IMPLY(a_word_follows, cmd_valid && cmd_ready, ##1 res_valid, "no response word after command")
	`SPQ_IMPLY(a_empty_flag, res_valid, is_empty == (entry_count == '0), "empty flag disagrees with count")
	`SPQ_IMPLY(a_empty_err, res_valid && (status == spq_pkg::ST_EMPTY), is_empty && (head_payload == '0) && (head_priority == '0), "empty error with live head")
	`SPQ_IMPLY(a_full_count, res_valid && (status == spq_pkg::ST_FULL), entry_count == cap_ext[spq_pkg::COUNT_W-1:0], "full status below capacity")
	`SPQ_IMPLY(a_hold, res_valid && !res_ready, ##1 (res_valid && $stable(head_payload) && $stable(status)), "stalled response word changed")

endmodule

bind sorted_priority_queue_core spq_checker #(
	.CAPACITY (CAPACITY)
) u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_valid),
	.cmd_ready     (cmd_ready),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.head_payload  (head_payload),
	.head_priority (head_priority),
	.is_empty      (is_empty),
	.entry_count   (entry_count),
	.status        (status)
);

>>> tb/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;

	localparam int DEPTH = spq_pkg::CAPACITY_DEF;
	localparam logic [spq_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;
	localparam int DIR_N = 24;
	localparam int RAND_N = 1950;

	typedef struct packed {
		logic [spq_pkg::PAY_W-1:0]    pay;
		logic [spq_pkg::KEY_W-1:0]    pri;
		logic                         emp;
		logic [spq_pkg::COUNT_W-1:0]  cnt;
		logic [spq_pkg::STATUS_W-1:0] st;
	} head_word_t;

	typedef struct packed {
		logic [spq_pkg::OPCODE_W-1:0] op;
		logic [spq_pkg::KEY_W-1:0]    pri;
		logic [spq_pkg::PAY_W-1:0]    pay;
		logic                         fixed;
		head_word_t                   want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [spq_pkg::OPCODE_W-1:0] opcode = '0;
	logic [spq_pkg::KEY_W-1:0] key_priority = '0;
	logic [spq_pkg::PAY_W-1:0] payload = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [spq_pkg::PAY_W-1:0] head_payload;
	logic [spq_pkg::KEY_W-1:0] head_priority;
	logic is_empty;
	logic [spq_pkg::COUNT_W-1:0] entry_count;
	logic [spq_pkg::STATUS_W-1:0] status;

	logic [spq_pkg::KEY_W-1:0] held_prio [DEPTH];
	logic [spq_pkg::PAY_W-1:0] held_pay [DEPTH];
	int held_n = 0;

	head_word_t pending_heads [$];
	int errors = 0;
	int mismatches = 0;
	bit no_gaps = 1'b0;

	cmd_row_t dir_rows [DIR_N] = '{
		'{spq_pkg::OP_PEEK,   16'h0000, 32'h0000_0000, 1'b1,
			'{32'h0, 16'h0, 1'b1, 5'd0, spq_pkg::ST_EMPTY}},
		'{spq_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 16'h0, 1'b1, 5'd0, spq_pkg::ST_EMPTY}},
		'{OP_SPARE,  16'h0000, 32'h0000_0000, 1'b1,
			'{32'h0, 16'h0, 1'b1, 5'd0, spq_pkg::ST_EMPTY}},
		'{spq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 1'b1,
			'{32'h0, 16'h0, 1'b0, 5'd1, spq_pkg::ST_OK}},
		'{spq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd2, spq_pkg::ST_OK}},
		'{spq_pkg::OP_INSERT, 16'hFFFF, 32'h1234_5678, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd3, spq_pkg::ST_OK}},
		'{spq_pkg::OP_PEEK,   16'h0000, 32'h0000_0000, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd3, spq_pkg::ST_OK}},
		'{spq_pkg::OP_INSERT, 16'h8000, 32'h8000_0000, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h0001, 32'h0000_0001, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h8000, 32'hAAAA_AAAA, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h7FFF, 32'h5555_5555, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h0000, 32'h0000_0002, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'hFFFE, 32'hDEAD_BEEF, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h00FF, 32'h0F0F_0F0F, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'hFF00, 32'hF0F0_F0F0, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h8000, 32'h0000_0003, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h0010, 32'h7FFF_FFFF, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h5555, 32'h0000_0004, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'hAAAA, 32'h0000_0005, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h0001, 32'h0000_0006, 1'b0, '0},
		'{spq_pkg::OP_INSERT, 16'h4000, 32'hCAFE_F00D, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd16, spq_pkg::ST_FULL}},
		'{OP_SPARE,  16'h0000, 32'h0000_0000, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd16, spq_pkg::ST_OK}},
		'{spq_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
			'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 5'd15, spq_pkg::ST_OK}},
		'{spq_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0}
	};

	sorted_priority_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.opcode(opcode),
		.key_priority(key_priority),
		.payload(payload),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.head_payload(head_payload),
		.head_priority(head_priority),
		.is_empty(is_empty),
		.entry_count(entry_count),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic head_word_t head_of(logic [spq_pkg::STATUS_W-1:0] st);
		head_word_t w;
		w.pay = (held_n > 0) ? held_pay[0] : '0;
		w.pri = (held_n > 0) ? held_prio[0] : '0;
		w.emp = (held_n == 0);
		w.cnt = held_n[spq_pkg::COUNT_W-1:0];
		w.st = st;
		return w;
	endfunction

	function automatic head_word_t apply_queue_op(logic [spq_pkg::OPCODE_W-1:0] op,
			logic [spq_pkg::KEY_W-1:0] pri, logic [spq_pkg::PAY_W-1:0] pay);
		head_word_t w;
		int pos;
		if (op == spq_pkg::OP_INSERT) begin
			if (held_n >= DEPTH)
				return head_of(spq_pkg::ST_FULL);
			pos = 0;
			while (pos < held_n && held_prio[pos] >= pri)
				pos++;
			for (int k = held_n; k > pos; k--) begin
				held_prio[k] = held_prio[k-1];
				held_pay[k] = held_pay[k-1];
			end
			held_prio[pos] = pri;
			held_pay[pos] = pay;
			held_n++;
			return head_of(spq_pkg::ST_OK);
		end
		if (op == spq_pkg::OP_REMOVE) begin
			if (held_n == 0)
				return head_of(spq_pkg::ST_EMPTY);
			w.pay = held_pay[0];
			w.pri = held_prio[0];
			for (int k = 1; k < held_n; k++) begin
				held_prio[k-1] = held_prio[k];
				held_pay[k-1] = held_pay[k];
			end
			held_n--;
			w.emp = (held_n == 0);
			w.cnt = held_n[spq_pkg::COUNT_W-1:0];
			w.st = spq_pkg::ST_OK;
			return w;
		end
		return head_of((held_n == 0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK);
	endfunction

	task automatic send_word(logic [spq_pkg::OPCODE_W-1:0] op,
			logic [spq_pkg::KEY_W-1:0] pri, logic [spq_pkg::PAY_W-1:0] pay,
			logic fixed, head_word_t want);
		head_word_t w;
		while (!no_gaps && $urandom_range(0, 99) < 16) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		key_priority <= pri;
		payload <= pay;
		do
			@(posedge clk);
		while (!cmd_ready);
		w = apply_queue_op(op, pri, pay);
		pending_heads.push_back(fixed ? want : w);
		@(negedge clk);
	endtask

	always @(negedge clk)
		res_ready <= no_gaps || ($urandom_range(0, 99) >= 16);

	always @(posedge clk) begin
		head_word_t got;
		head_word_t want;
		if (arst_n && res_valid && res_ready) begin
			got = '{head_payload, head_priority, is_empty, entry_count, status};
			if (pending_heads.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: pay %h pri %h empty %b count %0d status %0d",
						got.pay, got.pri, got.emp, got.cnt, got.st);
			end else begin
				want = pending_heads.pop_front();
				if (got !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("exp/act: pay %h/%h pri %h/%h emp %b/%b cnt %0d/%0d st %0d/%0d",
							want.pay, got.pay, want.pri, got.pri, want.emp, got.emp,
							want.cnt, got.cnt, want.st, got.st);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_sorted_priority_queue_core: done, errors");
		$finish;
	end

	initial begin
		int mode;
		int r;
		int sel;
		logic [spq_pkg::OPCODE_W-1:0] op;
		logic [spq_pkg::KEY_W-1:0] pri;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].pri, dir_rows[i].pay,
				dir_rows[i].fixed, dir_rows[i].want);

		mode = 0;
		for (int i = 0; i < RAND_N; i++) begin
			if (i % 80 == 0)
				mode = $urandom_range(0, 2);
			no_gaps = (i >= 300 && i < 700);
			// hold off until the queue has answered every word
			if (i == RAND_N / 2)
				while (pending_heads.size() != 0) begin
					cmd_valid <= 1'b0;
					@(negedge clk);
				end
			r = $urandom_range(0, 99);
			if (r < 3)
				op = OP_SPARE;
			else if (r < ((mode == 0) ? 75 : (mode == 1) ? 25 : 45))
				op = spq_pkg::OP_INSERT;
			else if (r < ((mode == 0) ? 90 : 85))
				op = spq_pkg::OP_REMOVE;
			else
				op = spq_pkg::OP_PEEK;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				pri = '0;
			else if (sel == 1)
				pri = '1;
			else if (sel < 6)
				pri = spq_pkg::KEY_W'($urandom_range(0, 7));
			else
				pri = spq_pkg::KEY_W'($urandom());
			send_word(op, pri, $urandom(), 1'b0, '0);
		end
		no_gaps = 1'b0;
		cmd_valid <= 1'b0;

		while (pending_heads.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_heads.size() == 0)
			$display("tb_sorted_priority_queue_core: done, clean");
		else
			$display("tb_sorted_priority_queue_core: done, errors");
		$finish;
	end

endmodule
